// File: hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int PRIO_W        = 2;
    localparam int TAG_W         = 32;
    localparam int AGE_W         = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LIST   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_CLEAR,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        SPQ_IDLE,
        SPQ_LIST
    } spq_state_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic [AGE_W-1:0]  age;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ins;
    } cell_cmd_t;

endpackage

// File: hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::entry_t    head_entry,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_valid,
    input  logic               left_goes,
    input  spq_pkg::entry_t    right_entry,
    input  logic               right_valid,
    output spq_pkg::entry_t    entry,
    output logic               valid,
    output logic               goes
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            valid_reg;
    logic            valid_next;

    // The new entry sorts ahead of this slot when the slot is empty or less urgent.
    assign goes = !valid_reg || (entry_reg.prio > cmd.ins.prio);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (cmd.op)
            spq_pkg::CELL_INSERT:
            begin
                if (left_goes)
                begin
                    entry_next = left_entry;
                    valid_next = left_valid;
                end
                else if (goes)
                begin
                    entry_next = cmd.ins;
                    valid_next = 1'b1;
                end
            end
            spq_pkg::CELL_REMOVE:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            spq_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            spq_pkg::CELL_ROTATE:
            begin
                // tail slot wraps the head around; empty slots hold
                if (valid_reg)
                begin
                    entry_next = right_valid ? right_entry : head_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

// File: hdl/stable_priority_queue.sv
// Stable priority queue top level: chain of sorted cells, command decode, result register.
//
// Command channel (cmd_valid / cmd_stall) carries one operation per beat:
// insert, remove head, clear all or list. Result channel (res_valid /
// res_stall) returns status, rank, entry fields and a last flag.
// Priority 0 is served first; equal priorities leave in arrival order.
// For insert, remove and clear, the chain of DEPTH cells compares and
// shifts in parallel, and the single result beat is valid the cycle
// after the command beat. A new command is taken every cycle while
// the result register drains and no list is in progress.
// List on a queue of n entries gives n beats, one per cycle, by rotating
// the occupied cells through the head slot; it stalls the command channel
// until its last beat is loaded, and leaves the queue as it was.
// Reset empties the queue and drops any pending result. While the result
// receiver stalls, the result register holds its beat and the command
// channel stalls too; listing pauses without losing its place.
module stable_priority_queue
#(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [1:0]                     opcode,
    input  logic [spq_pkg::PRIO_W-1:0]     priority_class,
    input  logic [spq_pkg::TAG_W-1:0]      entry_tag,
    input  logic [spq_pkg::AGE_W-1:0]      entry_age,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [1:0]                     status,
    output logic [$clog2(DEPTH+1)-1:0]     rank,
    output logic [spq_pkg::PRIO_W-1:0]     out_priority,
    output logic [spq_pkg::TAG_W-1:0]      out_tag,
    output logic [spq_pkg::AGE_W-1:0]      out_age,
    output logic                           last
);

    localparam int CW = $clog2(DEPTH + 1);

    spq_pkg::spq_state_t state_reg;
    spq_pkg::spq_state_t state_next;
    logic [CW-1:0]       occ_reg;
    logic [CW-1:0]       occ_next;
    logic [CW-1:0]       rank_ctr_reg;
    logic [CW-1:0]       rank_ctr_next;

    logic                res_valid_reg;
    logic                res_valid_next;
    spq_pkg::status_t    res_status_reg;
    spq_pkg::status_t    res_status_next;
    logic [CW-1:0]       res_rank_reg;
    logic [CW-1:0]       res_rank_next;
    spq_pkg::entry_t     res_entry_reg;
    spq_pkg::entry_t     res_entry_next;
    logic                res_last_reg;
    logic                res_last_next;

    spq_pkg::cell_cmd_t  cell_cmd;
    spq_pkg::entry_t     cell_entry [DEPTH];
    logic [DEPTH-1:0]    cell_valid;
    logic [DEPTH-1:0]    cell_goes;
    spq_pkg::entry_t     ins_entry;
    spq_pkg::opcode_t    op;
    logic                slot_free;
    logic                cmd_accept;
    logic                load_res;
    logic                list_done;

    assign op        = spq_pkg::opcode_t'(opcode);
    assign slot_free = !res_valid_reg || !res_stall;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign list_done = (rank_ctr_reg == occ_reg);

    assign ins_entry.prio = priority_class;
    assign ins_entry.tag  = entry_tag;
    assign ins_entry.age  = entry_age;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t l_entry;
        spq_pkg::entry_t r_entry;
        logic            l_valid;
        logic            l_goes;
        logic            r_valid;

        if (i == 0)
        begin : g_first
            assign l_entry = '0;
            assign l_valid = 1'b0;
            assign l_goes  = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_entry = cell_entry[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_goes  = cell_goes[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_lastc
            assign r_entry = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_entry = cell_entry[i+1];
            assign r_valid = cell_valid[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd),
            .head_entry  (cell_entry[0]),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_goes   (l_goes),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .goes        (cell_goes[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::SPQ_IDLE:
            begin
                if (cmd_accept && (op == spq_pkg::OP_LIST) && (occ_reg != '0))
                begin
                    state_next = spq_pkg::SPQ_LIST;
                end
            end
            spq_pkg::SPQ_LIST:
            begin
                if (slot_free && list_done)
                begin
                    state_next = spq_pkg::SPQ_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::SPQ_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        cmd_stall       = 1'b1;
        cell_cmd.op     = spq_pkg::CELL_HOLD;
        cell_cmd.ins    = ins_entry;
        occ_next        = occ_reg;
        rank_ctr_next   = rank_ctr_reg;
        load_res        = 1'b0;
        res_status_next = spq_pkg::ST_OK;
        res_rank_next   = '0;
        res_entry_next  = '0;
        res_last_next   = 1'b1;
        case (state_reg)
            spq_pkg::SPQ_IDLE:
            begin
                cmd_stall = !slot_free;
                if (cmd_valid && slot_free)
                begin
                    load_res = 1'b1;
                    case (op)
                        spq_pkg::OP_INSERT:
                        begin
                            if (occ_reg == CW'(DEPTH))
                            begin
                                res_status_next = spq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_cmd.op = spq_pkg::CELL_INSERT;
                                occ_next    = occ_reg + 1'b1;
                            end
                        end
                        spq_pkg::OP_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_status_next = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                res_entry_next = cell_entry[0];
                                cell_cmd.op    = spq_pkg::CELL_REMOVE;
                                occ_next       = occ_reg - 1'b1;
                            end
                        end
                        spq_pkg::OP_CLEAR:
                        begin
                            cell_cmd.op = spq_pkg::CELL_CLEAR;
                            occ_next    = '0;
                        end
                        spq_pkg::OP_LIST:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_status_next = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // first beat comes from the list state
                                load_res      = 1'b0;
                                rank_ctr_next = CW'(1);
                            end
                        end
                        default:
                        begin
                            load_res = 1'b0;
                        end
                    endcase
                end
            end
            spq_pkg::SPQ_LIST:
            begin
                if (slot_free)
                begin
                    load_res       = 1'b1;
                    res_rank_next  = rank_ctr_reg;
                    res_entry_next = cell_entry[0];
                    res_last_next  = list_done;
                    cell_cmd.op    = spq_pkg::CELL_ROTATE;
                    rank_ctr_next  = rank_ctr_reg + 1'b1;
                end
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    assign res_valid_next = load_res ? 1'b1 : (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::SPQ_IDLE;
            occ_reg       <= '0;
            rank_ctr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rank_ctr_reg  <= rank_ctr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // hold the beat until it is taken
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_status_reg <= res_status_next;
            res_rank_reg   <= res_rank_next;
            res_entry_reg  <= res_entry_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign status       = res_status_reg;
    assign rank         = res_rank_reg;
    assign out_priority = res_entry_reg.prio;
    assign out_tag      = res_entry_reg.tag;
    assign out_age      = res_entry_reg.age;
    assign last         = res_last_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    a_valid_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == 32'(occ_reg))
        else $error("cell valid bits disagree with occupancy");

    a_partial_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_stall && !res_last_reg |-> state_reg == spq_pkg::SPQ_LIST)
        else $error("non-final beat outside a list");

    a_rank_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_rank_reg != '0) |-> res_status_reg == spq_pkg::ST_OK)
        else $error("ranked beat with bad status");

    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept && (op == spq_pkg::OP_INSERT) && (occ_reg == CW'(DEPTH))
        |=> $stable(occ_reg) && $stable(cell_valid))
        else $error("refused insert changed the queue");
`endif

endmodule
